>>> hdl/sta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, register indexes and reset values of the threshold alarm.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SUSTAIN_W  = 8;
  localparam int unsigned HOLDOFF_W  = 10;
  localparam int unsigned HOLDSEC_W  = 16;   // 1023 * 60 fits
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned DATA_W     = 24;
  localparam int unsigned RUN_BITS_DEF = 8;

  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned BATTERY_SUSTAIN    = 1;

  typedef enum logic [CH_W-1:0] {
    CH_CPU     = 2'd0,
    CH_MEM     = 2'd1,
    CH_BATTERY = 2'd2,
    CH_POWER   = 2'd3
  } channel_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_CPU_LIMIT     = 3'd0,
    REG_CPU_SUSTAIN   = 3'd1,
    REG_MEM_LIMIT     = 3'd2,
    REG_MEM_SUSTAIN   = 3'd3,
    REG_BATTERY_FLOOR = 3'd4,
    REG_POWER_LIMIT   = 3'd5,
    REG_HOLDOFF       = 3'd6
  } reg_index_t;

  localparam logic [SAMPLE_W-1:0]  CPU_LIMIT_RST     = 24'd23040;
  localparam logic [SUSTAIN_W-1:0] CPU_SUSTAIN_RST   = 8'd5;
  localparam logic [SAMPLE_W-1:0]  MEM_LIMIT_RST     = 24'd23040;
  localparam logic [SUSTAIN_W-1:0] MEM_SUSTAIN_RST   = 8'd5;
  localparam logic [SAMPLE_W-1:0]  BATTERY_FLOOR_RST = 24'd2560;
  localparam logic [SAMPLE_W-1:0]  POWER_LIMIT_RST   = 24'd12800;
  localparam logic [HOLDSEC_W-1:0] HOLDOFF_SECS_RST  = 16'd900;   // 15 minutes

  typedef struct packed {
    logic [SAMPLE_W-1:0]  cpu_limit;
    logic [SUSTAIN_W-1:0] cpu_sustain;
    logic [SAMPLE_W-1:0]  mem_limit;
    logic [SUSTAIN_W-1:0] mem_sustain;
    logic [SAMPLE_W-1:0]  battery_floor;
    logic [SAMPLE_W-1:0]  power_limit;
    logic [HOLDSEC_W-1:0] holdoff_secs;
  } cfg_t;

  typedef struct packed {
    logic fire;
  } verdict_t;

endpackage
`default_nettype wire

>>> hdl/sustained_threshold_alarm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sustained_threshold_alarm
// Four-channel threshold monitor with sustain count and alert holdoff.
// ----------------------------------------------------------------------------
//   port group   dir  handshake           payload
//   input        in   in_valid/in_stall   channel, sample, quality_known,
//                                          now_seconds
//   alert        out  out_valid/out_stall alert_channel, alert_time,
//                                          alert_sample
//   config       in   wr_en               wr_index, wr_data
//
// One item per cycle while in_stall is low. An item is held in the input
// register, evaluated against its channel's state there, and any alert
// moves on into the output register once that register is free.
// Channel state is updated as the item leaves the input register, so the
// next item of the same channel sees it. Synchronous reset clears the valid
// flags and the per-channel state and loads the default configuration.
// in_stall rises only while an alert waits and out_stall is high.
// ----------------------------------------------------------------------------
module sustained_threshold_alarm
  import sta_pkg::*;
#(
  parameter int unsigned RUN_BITS = RUN_BITS_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CH_W-1:0]      channel,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                 quality_known,
  input  wire logic [TIME_W-1:0]    now_seconds,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_W-1:0]           alert_channel,
  output logic [TIME_W-1:0]         alert_time,
  output logic signed [SAMPLE_W-1:0] alert_sample,

  input  wire logic                 wr_en,
  input  wire logic [INDEX_W-1:0]   wr_index,
  input  wire logic [DATA_W-1:0]    wr_data
);

  cfg_t     cfg;
  verdict_t verdict;

  logic                s1_valid;
  logic [CH_W-1:0]     s1_channel;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_quality;
  logic [TIME_W-1:0]   s1_now;

  logic out_free;
  logic go;

  assign out_free = !out_valid || !out_stall;
  assign go       = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  sta_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  sta_eval #(
    .RUN_BITS (RUN_BITS)
  ) u_eval (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .go            (go),
    .channel       (s1_channel),
    .sample        (s1_sample),
    .quality_known (s1_quality),
    .now_seconds   (s1_now),
    .verdict       (verdict)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_channel <= channel;
      s1_sample  <= sample;
      s1_quality <= quality_known;
      s1_now     <= now_seconds;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= go && verdict.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (go && verdict.fire) begin
      alert_channel <= s1_channel;
      alert_time    <= s1_now;
      alert_sample  <= s1_sample;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sta_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_cfg
// Configuration registers; holdoff is kept in seconds, scaled at write time.
// ----------------------------------------------------------------------------
module sta_cfg
  import sta_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [INDEX_W-1:0]  wr_index,
  input  wire logic [DATA_W-1:0]   wr_data,
  output cfg_t                     cfg
);

  cfg_t cfg_q;
  logic [HOLDSEC_W-1:0] holdoff_scaled;

  assign holdoff_scaled = HOLDSEC_W'(wr_data[HOLDOFF_W-1:0]) *
                          HOLDSEC_W'(SECONDS_PER_MINUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.cpu_limit     <= CPU_LIMIT_RST;
      cfg_q.cpu_sustain   <= CPU_SUSTAIN_RST;
      cfg_q.mem_limit     <= MEM_LIMIT_RST;
      cfg_q.mem_sustain   <= MEM_SUSTAIN_RST;
      cfg_q.battery_floor <= BATTERY_FLOOR_RST;
      cfg_q.power_limit   <= POWER_LIMIT_RST;
      cfg_q.holdoff_secs  <= HOLDOFF_SECS_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_CPU_LIMIT:     cfg_q.cpu_limit     <= wr_data[SAMPLE_W-1:0];
        REG_CPU_SUSTAIN:   cfg_q.cpu_sustain   <= wr_data[SUSTAIN_W-1:0];
        REG_MEM_LIMIT:     cfg_q.mem_limit     <= wr_data[SAMPLE_W-1:0];
        REG_MEM_SUSTAIN:   cfg_q.mem_sustain   <= wr_data[SUSTAIN_W-1:0];
        REG_BATTERY_FLOOR: cfg_q.battery_floor <= wr_data[SAMPLE_W-1:0];
        REG_POWER_LIMIT:   cfg_q.power_limit   <= wr_data[SAMPLE_W-1:0];
        REG_HOLDOFF:       cfg_q.holdoff_secs  <= holdoff_scaled;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hdl/sta_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_eval
// Per-channel run counters and last alert times; decides whether the item
// in the input register fires, and updates that channel's state on advance.
// ----------------------------------------------------------------------------
module sta_eval
  import sta_pkg::*;
#(
  parameter int unsigned RUN_BITS = RUN_BITS_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 go,
  input  wire logic [CH_W-1:0]      channel,
  input  wire logic [SAMPLE_W-1:0]  sample,
  input  wire logic                 quality_known,
  input  wire logic [TIME_W-1:0]    now_seconds,
  output verdict_t                  verdict
);

  localparam int unsigned CMP_W = (RUN_BITS > SUSTAIN_W) ? RUN_BITS : SUSTAIN_W;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  logic [RUN_BITS-1:0] run [NUM_CH];
  logic [TIME_W-1:0]   last_time [NUM_CH];

  logic                ignore;
  logic                violated;
  logic [SUSTAIN_W-1:0] sustain;
  logic [RUN_BITS-1:0] run_cur;
  logic [RUN_BITS-1:0] run_inc;
  logic [TIME_W-1:0]   last;
  logic [TIME_W:0]     elapsed;
  logic                reached;
  logic                held;
  logic                fire;

  always_comb begin
    ignore   = 1'b0;
    violated = 1'b0;
    sustain  = cfg.cpu_sustain;
    case (channel_t'(channel))
      CH_CPU: begin
        violated = $signed(sample) >= $signed(cfg.cpu_limit);
      end
      CH_MEM: begin
        violated = $signed(sample) >= $signed(cfg.mem_limit);
        sustain  = cfg.mem_sustain;
      end
      CH_BATTERY: begin
        violated = $signed(sample) <= $signed(cfg.battery_floor);
        sustain  = SUSTAIN_W'(BATTERY_SUSTAIN);
      end
      CH_POWER: begin
        ignore   = !quality_known;
        violated = $signed(sample) >= $signed(cfg.power_limit);
      end
      default: ;
    endcase
  end

  assign run_cur = run[channel];
  assign last    = last_time[channel];
  assign run_inc = (run_cur == RUN_MAX) ? run_cur : run_cur + RUN_BITS'(1);
  assign reached = CMP_W'(run_inc) >= CMP_W'(sustain);

  // negative elapsed (time ran backward) counts as inside the holdoff
  assign elapsed = {1'b0, now_seconds} - {1'b0, last};
  assign held    = (last != '0) &&
                   (elapsed[TIME_W] || (elapsed[TIME_W-1:0] < TIME_W'(cfg.holdoff_secs)));

  assign fire = !ignore && violated && reached && !held;
  assign verdict.fire = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        run[i]       <= '0;
        last_time[i] <= '0;
      end
    end else if (go && !ignore) begin
      if (!violated) begin
        run[channel] <= '0;
      end else if (fire) begin
        run[channel]       <= '0;
        last_time[channel] <= now_seconds;
      end else begin
        run[channel] <= run_inc;
      end
    end
  end

endmodule
`default_nettype wire

>>> sim/sustained_threshold_alarm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sustained_threshold_alarm_tb
// Sends tagged samples to the alarm, keeps its own copy of the per-channel
// violation runs, last alert times and registers to predict every alert,
// and compares each alert field by field. Covers boundaries, counter
// saturation, output backpressure and randomized register settings.
// ----------------------------------------------------------------------------
module sustained_threshold_alarm_tb
  import sta_pkg::*;
;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 20;
  localparam int SMAX_I      = 8388607;
  localparam int SMIN_I      = -8388608;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;
  localparam logic [RUN_BITS_DEF-1:0]    RUN_TOP = '1;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [TIME_W-1:0]   at;
    logic [SAMPLE_W-1:0] smp;
  } alert_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CH_W-1:0]            channel = CH_CPU;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       quality_known = 1'b0;
  logic [TIME_W-1:0]          now_seconds = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CH_W-1:0]            alert_channel;
  logic [TIME_W-1:0]          alert_time;
  logic signed [SAMPLE_W-1:0] alert_sample;
  logic                       wr_en = 1'b0;
  logic [INDEX_W-1:0]         wr_index = REG_CPU_LIMIT;
  logic [DATA_W-1:0]          wr_data = '0;

  // local copy of the register file
  logic signed [SAMPLE_W-1:0] lim_cpu    = CPU_LIMIT_RST;
  logic [SUSTAIN_W-1:0]       need_cpu   = CPU_SUSTAIN_RST;
  logic signed [SAMPLE_W-1:0] lim_mem    = MEM_LIMIT_RST;
  logic [SUSTAIN_W-1:0]       need_mem   = MEM_SUSTAIN_RST;
  logic signed [SAMPLE_W-1:0] floor_batt = BATTERY_FLOOR_RST;
  logic signed [SAMPLE_W-1:0] lim_power  = POWER_LIMIT_RST;
  logic [HOLDOFF_W-1:0]       hold_min   = HOLDOFF_W'(HOLDOFF_SECS_RST / SECONDS_PER_MINUTE);

  // per-channel state
  logic [RUN_BITS_DEF-1:0] run_len   [NUM_CH] = '{default: '0};
  logic [TIME_W-1:0]       last_fire [NUM_CH] = '{default: '0};

  alert_t alerts_due[$];

  logic [TIME_W-1:0] wall = '0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int alerts_seen = 0;
  int reg_writes = 0;
  int errors = 0;

  sustained_threshold_alarm dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel       (channel),
    .sample        (sample),
    .quality_known (quality_known),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alert_channel (alert_channel),
    .alert_time    (alert_time),
    .alert_sample  (alert_sample),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always #1 clk = ~clk;

  // Advance the run and holdoff state of one channel; queue the alert it causes.
  function automatic void track_sample(channel_t ch, logic signed [SAMPLE_W-1:0] s,
                                       logic q, logic [TIME_W-1:0] now);
    logic hit;
    logic [SUSTAIN_W-1:0] need;
    int unsigned hold_s;
    alert_t a;
    case (ch)
      CH_CPU: begin
        hit = s >= lim_cpu;
        need = need_cpu;
      end
      CH_MEM: begin
        hit = s >= lim_mem;
        need = need_mem;
      end
      CH_BATTERY: begin
        hit = s <= floor_batt;
        need = SUSTAIN_W'(BATTERY_SUSTAIN);
      end
      default: begin
        if (!q) return;
        hit = s >= lim_power;
        need = need_cpu;
      end
    endcase
    if (!hit) begin
      run_len[ch] = '0;
      return;
    end
    if (run_len[ch] != RUN_TOP) run_len[ch] = run_len[ch] + RUN_BITS_DEF'(1);
    if (run_len[ch] < need) return;
    hold_s = hold_min * SECONDS_PER_MINUTE;
    // a recorded time of zero reads as never alerted
    if (last_fire[ch] != '0 && (now < last_fire[ch] || now - last_fire[ch] < hold_s)) return;
    last_fire[ch] = now;
    run_len[ch] = '0;
    a.ch = ch;
    a.at = now;
    a.smp = s;
    alerts_due.push_back(a);
  endfunction

  // Sample close to the channel's level, on the alarming side or just past it.
  function automatic logic signed [SAMPLE_W-1:0] near_level(channel_t ch, bit hit);
    int lvl;
    int d;
    int v;
    case (ch)
      CH_CPU:     lvl = lim_cpu;
      CH_MEM:     lvl = lim_mem;
      CH_BATTERY: lvl = floor_batt;
      default:    lvl = lim_power;
    endcase
    d = $urandom_range(0, 300);
    if (ch == CH_BATTERY) v = hit ? lvl - d : lvl + 1 + d;
    else v = hit ? lvl + d : lvl - 1 - d;
    if (v > SMAX_I) v = SMAX_I;
    if (v < SMIN_I) v = SMIN_I;
    return v[SAMPLE_W-1:0];
  endfunction

  // Mostly small forward steps, now and then a big jump or a step back.
  function automatic logic [TIME_W-1:0] tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) wall = wall - $urandom_range(1, 2000);
    else if (r < 6) wall = wall + $urandom_range(1000, 70000);
    else wall = wall + $urandom_range(0, 90);
    return wall;
  endfunction

  function automatic logic [SUSTAIN_W-1:0] rand_sustain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 8'd1;
    if (r == 2 && $urandom_range(0, 3) == 0) return 8'd255;
    return SUSTAIN_W'($urandom_range(2, 6));
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SMIN;
    if (r == 1) return SMAX;
    if (r < 4) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 40000) - 8000);
  endfunction

  task automatic send_item(channel_t ch, logic signed [SAMPLE_W-1:0] s, logic q,
                           logic [TIME_W-1:0] now);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample <= s;
    quality_known <= q;
    now_seconds <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_CPU_LIMIT:     lim_cpu = val;
      REG_CPU_SUSTAIN:   need_cpu = val[SUSTAIN_W-1:0];
      REG_MEM_LIMIT:     lim_mem = val;
      REG_MEM_SUSTAIN:   need_mem = val[SUSTAIN_W-1:0];
      REG_BATTERY_FLOOR: floor_batt = val;
      REG_POWER_LIMIT:   lim_power = val;
      REG_HOLDOFF:       hold_min = val[HOLDOFF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
    reg_writes++;
  endtask

  // Idle the input, let all alerts out, then give the pipeline time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (alerts_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_defaults();
    // cpu run exactly at the limit; the first alert lands at time zero
    repeat (5) send_item(CH_CPU, lim_cpu, 1'b0, 32'd0);
    // zero still means never alerted, so no holdoff here
    repeat (5) send_item(CH_CPU, lim_cpu, 1'b1, 32'd10);
    send_item(CH_BATTERY, floor_batt, 1'b0, 32'd20);
    send_item(CH_BATTERY, floor_batt + 24'sd1, 1'b1, 32'd25);
    send_item(CH_BATTERY, SMIN, 1'b0, 32'd30);      // inside holdoff
    send_item(CH_BATTERY, SMIN, 1'b1, 32'd920);     // window just ended
    send_item(CH_BATTERY, SMIN, 1'b0, 32'd10);      // time went backward
    send_item(CH_BATTERY, SMIN, 1'b1, 32'd1819);    // one second short
    send_item(CH_MEM, lim_mem - 24'sd1, 1'b1, 32'd1900);
    repeat (2) send_item(CH_MEM, SMAX, 1'b0, 32'd2000);
    send_item(CH_MEM, SMIN, 1'b1, 32'd2001);
    // unknown quality power is dropped without touching the run
    send_item(CH_POWER, SMAX, 1'b0, 32'hFFFF_FFFF);
    repeat (5) send_item(CH_POWER, lim_power, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_run_saturation();
    settle();
    write_reg(REG_CPU_SUSTAIN, 24'h5A_00FF);
    write_reg(REG_MEM_SUSTAIN, 24'hA5_FF00);
    write_reg(REG_HOLDOFF, 24'hFF_FC00);
    wall = 32'd5000;
    // run must climb to the top of the counter before it fires
    repeat (257) send_item(CH_CPU, lim_cpu, 1'b0, tick());
    send_item(CH_POWER, lim_power, 1'b1, wall + 1);
    wall = wall + 10;
    // zero sustain fires on every violation
    repeat (4) begin
      wall = wall + 1;
      send_item(CH_MEM, near_level(CH_MEM, 1'b1), 1'b0, wall);
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(REG_BATTERY_FLOOR, SMAX);
    write_reg(REG_HOLDOFF, '0);
    quiet = 1'b1;
    hold_req++;
    repeat (40) begin
      wall = wall + $urandom_range(1, 50);
      send_item(CH_BATTERY, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)), wall);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_settings();
    channel_t ch;
    int len;
    int n;
    bit tidy;
    logic q;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_reg(REG_CPU_LIMIT, SMIN);
        write_reg(REG_CPU_SUSTAIN, 24'hFFFF00);
        write_reg(REG_MEM_LIMIT, SMIN);
        write_reg(REG_MEM_SUSTAIN, 24'hFFFF00);
        write_reg(REG_BATTERY_FLOOR, SMIN);
        write_reg(REG_POWER_LIMIT, SMIN);
        write_reg(REG_HOLDOFF, 24'hFFFC00);
      end else if (p == 1) begin
        write_reg(REG_CPU_LIMIT, SMAX);
        write_reg(REG_CPU_SUSTAIN, 24'h0000FF);
        write_reg(REG_MEM_LIMIT, SMAX);
        write_reg(REG_MEM_SUSTAIN, 24'h0000FF);
        write_reg(REG_BATTERY_FLOOR, SMAX);
        write_reg(REG_POWER_LIMIT, SMAX);
        write_reg(REG_HOLDOFF, 24'h0003FF);
      end else begin
        write_reg(REG_CPU_LIMIT, rand_level());
        write_reg(REG_CPU_SUSTAIN, {16'($urandom_range(0, 65535)), rand_sustain()});
        write_reg(REG_MEM_LIMIT, rand_level());
        write_reg(REG_MEM_SUSTAIN, {16'($urandom_range(0, 65535)), rand_sustain()});
        write_reg(REG_BATTERY_FLOOR, rand_level());
        write_reg(REG_POWER_LIMIT, rand_level());
        write_reg(REG_HOLDOFF, {14'($urandom_range(0, 16383)),
                                10'($urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 20))});
      end
      wall = (p == 3) ? 32'hFFFF_FF00 : $urandom;   // one phase wraps the clock
      quiet = (p == 5);
      n = 0;
      while (n < PHASE_ITEMS) begin
        ch = channel_t'($urandom_range(0, NUM_CH - 1));
        len = $urandom_range(1, 8);
        tidy = $urandom_range(0, 9) < 8;
        for (int k = 0; k < len; k++) begin
          if (tidy) begin
            q = (ch != CH_POWER) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
            send_item(ch, near_level(ch, 1'b1), q, tick());
            if (ch != CH_POWER || q) n++;
          end else begin
            send_item(channel_t'($urandom_range(0, NUM_CH - 1)), SAMPLE_W'($urandom),
                      1'($urandom_range(0, 1)), tick());
            n++;
          end
        end
        if (tidy && $urandom_range(0, 1)) begin
          send_item(ch, near_level(ch, 1'b0), 1'b1, tick());
          n++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      track_sample(channel_t'(channel), sample, quality_known, now_seconds);
  end

  // alert checker
  always @(posedge clk) begin
    alert_t want;
    if (!rst && out_valid && !out_stall) begin
      alerts_seen++;
      if (alerts_due.size() == 0) begin
        $display("[%0t] unexpected alert: expected none, got ch %0d time %0d sample %0d",
                 $time, alert_channel, alert_time, $signed(alert_sample));
        errors++;
      end else begin
        want = alerts_due.pop_front();
        if (alert_channel !== want.ch) begin
          $display("[%0t] alert_channel: expected %0d, got %0d", $time, want.ch, alert_channel);
          errors++;
        end
        if (alert_time !== want.at) begin
          $display("[%0t] alert_time: expected %0d, got %0d", $time, want.at, alert_time);
          errors++;
        end
        if (alert_sample !== want.smp) begin
          $display("[%0t] alert_sample: expected %0d, got %0d", $time,
                   $signed(want.smp), $signed(alert_sample));
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] nothing moved for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_run_saturation();
    test_backpressure();
    test_random_settings();
    settle();
    if (alerts_due.size() != 0) begin
      $display("[%0t] %0d expected alerts never arrived", $time, alerts_due.size());
      errors++;
    end
    $display("Run: %0d samples sent, %0d alerts checked, %0d register writes, %0d errors",
             items_sent, alerts_seen, reg_writes, errors);
    $display("Covered boundaries, run saturation, held output and %0d random settings",
             PHASES);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sustained_threshold_alarm.f
hdl/sta_pkg.sv
hdl/sta_cfg.sv
hdl/sta_eval.sv
hdl/sustained_threshold_alarm.sv
sim/sustained_threshold_alarm_tb.sv
